@@ hdl/loeffler_idct_8x8_pixels_core_defines.svh @@
// assertion macros for the 8x8 inverse dct core
`ifndef LOEFFLER_IDCT_8X8_PIXELS_CORE_DEFINES_SVH
`define LOEFFLER_IDCT_8X8_PIXELS_CORE_DEFINES_SVH

// same-cycle implication, reset masked
`define LIC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masked
`define LIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lic_pkg.sv @@
// shared types, constants and arithmetic helpers of the 8x8 inverse dct core
package lic_pkg;

    localparam int LIC_COEF_WIDTH = 16;
    localparam int LIC_VW         = 40;
    localparam int LIC_PW         = 58;
    localparam int LIC_LAT        = 4;

    localparam logic signed [15:0] K_INV_SQRT2 = 16'sd11585;
    localparam logic signed [15:0] K_R6C       = 16'sd8867;
    localparam logic signed [15:0] K_R6S       = 16'sd21407;
    localparam logic signed [15:0] K_R1C       = 16'sd22725;
    localparam logic signed [15:0] K_R1S       = 16'sd4520;
    localparam logic signed [15:0] K_R3C       = 16'sd19266;
    localparam logic signed [15:0] K_R3S       = 16'sd12873;

    typedef logic signed [LIC_VW-1:0] t_val;
    typedef logic signed [LIC_PW-1:0] t_prod;
    typedef logic signed [31:0]       t_store;
    typedef t_val                     t_vec [8];
    typedef logic [7:0]               t_pix;

    typedef struct packed {
        logic shift;
        logic load;
    } t_lane_ctl;

    function automatic t_val q14(input t_prod p);
        t_prod s;
        s = p + t_prod'(8192);
        return t_val'(s >>> 14);
    endfunction

    function automatic t_store sat32(input t_val v);
        if (v > t_val'(32'sh7fffffff))
            return 32'sh7fffffff;
        if (v < -t_val'(33'sh080000000))
            return 32'sh80000000;
        return t_store'(v);
    endfunction

    function automatic t_pix to_pixel(input t_val v);
        t_val p;
        p = ((v + t_val'(64)) >>> 7) + t_val'(128);
        if (p < t_val'(0))
            return 8'd0;
        if (p > t_val'(255))
            return 8'd255;
        return t_pix'(p[7:0]);
    endfunction

endpackage

@@ hdl/lic_idct1d.sv @@
// four-stage pipelined 1-d loeffler inverse dct
module lic_idct1d
    import lic_pkg::*;
(
    input  logic i_clk,
    input  t_vec i_x,
    output t_vec o_y
);

    t_prod r_p2c, r_p6s, r_p2s, r_p6c, r_p7, r_p1;
    t_val  r_a0, r_a1, r_x3, r_x5;
    t_val  r_b [8];
    t_prod r_m5c, r_m6s, r_m5s, r_m6c, r_m4c, r_m7s, r_m4s, r_m7c;
    t_val  r_c [4];
    t_vec  r_y;

    t_val  n_a2, n_a3, n_a4, n_a7, n_b4, n_b7;
    t_val  n_r4, n_r5, n_r6, n_r7;

    always_comb begin
        n_a2 = q14(r_p2c - r_p6s);
        n_a3 = q14(r_p2s + r_p6c);
        n_a4 = q14(r_p7);
        n_a7 = q14(r_p1);
        n_b4 = n_a7 - n_a4;
        n_b7 = n_a7 + n_a4;
        n_r5 = q14(r_m5c - r_m6s);
        n_r6 = q14(r_m5s + r_m6c);
        n_r4 = q14(r_m4c - r_m7s);
        n_r7 = q14(r_m4s + r_m7c);
    end

    always_ff @(posedge i_clk) begin
        r_p2c <= t_prod'(i_x[2]) * t_prod'(K_R6C);
        r_p6s <= t_prod'(i_x[6]) * t_prod'(K_R6S);
        r_p2s <= t_prod'(i_x[2]) * t_prod'(K_R6S);
        r_p6c <= t_prod'(i_x[6]) * t_prod'(K_R6C);
        r_p7  <= t_prod'(i_x[7]) * t_prod'(K_INV_SQRT2);
        r_p1  <= t_prod'(i_x[1]) * t_prod'(K_INV_SQRT2);
        r_a0  <= i_x[0] + i_x[4];
        r_a1  <= i_x[0] - i_x[4];
        r_x3  <= i_x[3];
        r_x5  <= i_x[5];

        r_b[0] <= r_a0 + n_a3;
        r_b[1] <= r_a1 + n_a2;
        r_b[2] <= r_a1 - n_a2;
        r_b[3] <= r_a0 - n_a3;
        r_b[5] <= n_b7 - r_x3;
        r_b[6] <= n_b4 - r_x5;
        r_b[7] <= n_b7 + r_x3;
        r_b[4] <= n_b4 + r_x5;

        r_m5c <= t_prod'(r_b[5]) * t_prod'(K_R1C);
        r_m6s <= t_prod'(r_b[6]) * t_prod'(K_R1S);
        r_m5s <= t_prod'(r_b[5]) * t_prod'(K_R1S);
        r_m6c <= t_prod'(r_b[6]) * t_prod'(K_R1C);
        r_m4c <= t_prod'(r_b[4]) * t_prod'(K_R3C);
        r_m7s <= t_prod'(r_b[7]) * t_prod'(K_R3S);
        r_m4s <= t_prod'(r_b[4]) * t_prod'(K_R3S);
        r_m7c <= t_prod'(r_b[7]) * t_prod'(K_R3C);
        for (int i = 0; i < 4; i++) begin
            r_c[i] <= r_b[i];
        end

        r_y[0] <= r_c[0] + n_r7;
        r_y[1] <= r_c[1] + n_r6;
        r_y[2] <= r_c[2] + n_r5;
        r_y[3] <= r_c[3] + n_r4;
        r_y[4] <= r_c[3] - n_r4;
        r_y[5] <= r_c[2] - n_r5;
        r_y[6] <= r_c[1] - n_r6;
        r_y[7] <= r_c[0] - n_r7;
    end

    assign o_y = r_y;

endmodule

@@ hdl/lic_lane.sv @@
// one column lane: eight-row column store, column transform, pixel register
module lic_lane
    import lic_pkg::*;
(
    input  logic      i_clk,
    input  t_lane_ctl i_ctl,
    input  t_store    i_row_val,
    output t_pix      o_pix [8]
);

    t_store r_tap [8];
    t_vec   n_x;
    t_vec   w_y;
    t_pix   r_pix [8];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_x[i] = t_val'(r_tap[i]);
        end
    end

    lic_idct1d u_idct (
        .i_clk (i_clk),
        .i_x   (n_x),
        .o_y   (w_y)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int i = 0; i < 7; i++) begin
                r_tap[i] <= r_tap[i+1];
            end
            r_tap[7] <= i_row_val;
        end
        if (i_ctl.load) begin
            for (int i = 0; i < 8; i++) begin
                r_pix[i] <= to_pixel(w_y[i]);
            end
        end
    end

    assign o_pix = r_pix;

endmodule

@@ hdl/loeffler_idct_8x8_pixels_core.sv @@
// top level of the 8x8 inverse dct core: row transform, eight column lanes, row output
//
// channel  direction  handshake          payload
// input    in         i_valid / o_stall  i_coef_0..i_coef_7
// output   out        o_valid / i_stall  o_pix_0..o_pix_7, o_last_row
//
// a row request passes capture, then the 4-stage row transform pipeline
// the eighth row then runs the column lanes, then gives 8 output rows, one per
// cycle that the output is not stalled
// o_stall is high from acceptance until the row is stored or the block is emitted
// synchronous active-low reset clears the state machine and the row counter
module loeffler_idct_8x8_pixels_core
    import lic_pkg::*;
#(
    parameter int COEF_WIDTH = LIC_COEF_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_coef_0,
    input  logic signed [15:0] i_coef_1,
    input  logic signed [15:0] i_coef_2,
    input  logic signed [15:0] i_coef_3,
    input  logic signed [15:0] i_coef_4,
    input  logic signed [15:0] i_coef_5,
    input  logic signed [15:0] i_coef_6,
    input  logic signed [15:0] i_coef_7,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_pix_0,
    output logic [7:0]         o_pix_1,
    output logic [7:0]         o_pix_2,
    output logic [7:0]         o_pix_3,
    output logic [7:0]         o_pix_4,
    output logic [7:0]         o_pix_5,
    output logic [7:0]         o_pix_6,
    output logic [7:0]         o_pix_7,
    output logic               o_last_row
);

    typedef enum logic [1:0] {S_IDLE, S_ROW, S_COL, S_OUT} t_state;

    t_state    r_state;
    logic [2:0] r_cnt;
    logic [2:0] r_row_cnt;
    logic [2:0] r_orow;
    t_vec      r_x;
    t_vec      n_x;
    t_vec      w_y;
    logic signed [15:0] w_coef [8];
    t_lane_ctl n_ctl;
    t_pix      w_pix [8][8];
    logic      w_acc_in;
    logic      w_acc_out;

    assign w_coef[0] = i_coef_0;
    assign w_coef[1] = i_coef_1;
    assign w_coef[2] = i_coef_2;
    assign w_coef[3] = i_coef_3;
    assign w_coef[4] = i_coef_4;
    assign w_coef[5] = i_coef_5;
    assign w_coef[6] = i_coef_6;
    assign w_coef[7] = i_coef_7;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n_x[i] = t_val'($signed(w_coef[i][COEF_WIDTH-1:0])) <<< 4;
        end
    end

    assign w_acc_in  = i_valid && !o_stall;
    assign w_acc_out = o_valid && !i_stall;

    always_comb begin
        n_ctl.shift = (r_state == S_ROW) && (r_cnt == 3'(LIC_LAT));
        n_ctl.load  = (r_state == S_COL) && (r_cnt == 3'(LIC_LAT));
    end

    lic_idct1d u_row (
        .i_clk (i_clk),
        .i_x   (r_x),
        .o_y   (w_y)
    );

    for (genvar j = 0; j < 8; j++) begin : g_lane
        lic_lane u_lane (
            .i_clk     (i_clk),
            .i_ctl     (n_ctl),
            .i_row_val (sat32(w_y[j])),
            .o_pix     (w_pix[j])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_x <= n_x;
        end
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_row_cnt <= '0;
            r_orow    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (w_acc_in) begin
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    if (n_ctl.shift) begin
                        r_cnt     <= '0;
                        r_row_cnt <= r_row_cnt + 3'd1;
                        r_state   <= (r_row_cnt == 3'd7) ? S_COL : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_COL: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (n_ctl.load) begin
                        r_orow  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_acc_out) begin
                        r_orow <= r_orow + 3'd1;
                        if (r_orow == 3'd7) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = (r_state == S_OUT);
    assign o_last_row = (r_orow == 3'd7);
    assign o_pix_0    = w_pix[0][r_orow];
    assign o_pix_1    = w_pix[1][r_orow];
    assign o_pix_2    = w_pix[2][r_orow];
    assign o_pix_3    = w_pix[3][r_orow];
    assign o_pix_4    = w_pix[4][r_orow];
    assign o_pix_5    = w_pix[5][r_orow];
    assign o_pix_6    = w_pix[6][r_orow];
    assign o_pix_7    = w_pix[7][r_orow];

endmodule

@@ hdl/lic_checker.sv @@
// port-level assertions of the 8x8 inverse dct core and their bind
`include "loeffler_idct_8x8_pixels_core_defines.svh"

module lic_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_stall,
    input logic       o_last_row,
    input logic [7:0] o_pix_0
);

    `LIC_ASSERT_SAME(a_out_blocks_in, i_clk, i_rst_n, o_valid, o_stall, "input open while emitting")
    `LIC_ASSERT_NEXT(a_rows_contiguous, i_clk, i_rst_n, o_valid && !i_stall && !o_last_row, o_valid, "gap inside block")
    `LIC_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_valid && !i_stall && o_last_row, !o_valid && !o_stall, "block did not end")
    `LIC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_pix_0) && $stable(o_last_row), "stalled request changed")

endmodule

bind loeffler_idct_8x8_pixels_core lic_checker u_lic_checker (.*);

@@ tb/tb.sv @@
// testbench of the 8x8 inverse dct core: driven rows, predicted pixel rows, random idling
`timescale 1ns / 100ps

module tb;
    import lic_pkg::*;

    typedef struct {
        logic [7:0] pix [8];
        logic       last_row;
    } t_pix_row;

    class idct_scoreboard;
        longint   blk_store [64];
        int       row_idx;
        t_pix_row pending [$];
        int       errors;

        function new();
            row_idx = 0;
            errors = 0;
            foreach (blk_store[i]) blk_store[i] = 0;
        endfunction

        static function longint fdiv(longint v, int s);
            return v >>> s;
        endfunction

        static function longint rnd14(longint p);
            return fdiv(p + 8192, 14);
        endfunction

        static function void xform(input longint x [8], output longint y [8]);
            longint a0, a1, a2, a3, a4, a5, a6, a7;
            longint b0, b1, b2, b3, b4, b5, b6, b7;
            longint r4, r5, r6, r7;
            a0 = x[0] + x[4];
            a1 = x[0] - x[4];
            a2 = rnd14(x[2] * 8867 - x[6] * 21407);
            a3 = rnd14(x[2] * 21407 + x[6] * 8867);
            a4 = rnd14(x[7] * 11585);
            a5 = x[3];
            a6 = x[5];
            a7 = rnd14(x[1] * 11585);
            b0 = a0 + a3;
            b1 = a1 + a2;
            b2 = a1 - a2;
            b3 = a0 - a3;
            b4 = a7 - a4;
            b7 = a7 + a4;
            b5 = b7 - a5;
            b6 = b4 - a6;
            b7 = b7 + a5;
            b4 = b4 + a6;
            r5 = rnd14(b5 * 22725 - b6 * 4520);
            r6 = rnd14(b5 * 4520 + b6 * 22725);
            r4 = rnd14(b4 * 19266 - b7 * 12873);
            r7 = rnd14(b4 * 12873 + b7 * 19266);
            y[0] = b0 + r7;
            y[1] = b1 + r6;
            y[2] = b2 + r5;
            y[3] = b3 + r4;
            y[4] = b3 - r4;
            y[5] = b2 - r5;
            y[6] = b1 - r6;
            y[7] = b0 - r7;
        endfunction

        function void note_row(input logic signed [15:0] c [8]);
            longint x [8];
            longint y [8];
            longint v;
            t_pix_row pr [8];
            for (int i = 0; i < 8; i++) x[i] = longint'(c[i]) * 16;
            xform(x, y);
            for (int i = 0; i < 8; i++) begin
                v = y[i];
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                blk_store[row_idx * 8 + i] = v;
            end
            if (row_idx == 7) begin
                for (int j = 0; j < 8; j++) begin
                    for (int i = 0; i < 8; i++) x[i] = blk_store[i * 8 + j];
                    xform(x, y);
                    for (int i = 0; i < 8; i++) begin
                        v = fdiv(y[i] + 64, 7) + 128;
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                        pr[i].pix[j] = v[7:0];
                    end
                end
                for (int i = 0; i < 8; i++) begin
                    pr[i].last_row = (i == 7);
                    pending.push_back(pr[i]);
                end
            end
            row_idx = (row_idx + 1) % 8;
        endfunction

        function void check_row(input t_pix_row got);
            t_pix_row exp_row;
            if (pending.size() == 0) begin
                $error("unexpected output row");
                errors++;
                return;
            end
            exp_row = pending.pop_front();
            for (int i = 0; i < 8; i++)
                if (got.pix[i] !== exp_row.pix[i]) begin
                    $error("pix_%0d expected %0d got %0d", i, exp_row.pix[i], got.pix[i]);
                    errors++;
                end
            if (got.last_row !== exp_row.last_row) begin
                $error("last_row expected %0d got %0d", exp_row.last_row, got.last_row);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, i_stall;
    logic o_stall, o_valid, o_last_row;
    logic signed [15:0] i_coef [8];
    logic [7:0] o_pix [8];

    idct_scoreboard sb;
    int idle_cycles;
    int rows_in, rows_out;
    bit timed_out;

    loeffler_idct_8x8_pixels_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_coef_0(i_coef[0]), .i_coef_1(i_coef[1]), .i_coef_2(i_coef[2]),
        .i_coef_3(i_coef[3]), .i_coef_4(i_coef[4]), .i_coef_5(i_coef[5]),
        .i_coef_6(i_coef[6]), .i_coef_7(i_coef[7]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pix_0(o_pix[0]), .o_pix_1(o_pix[1]), .o_pix_2(o_pix[2]), .o_pix_3(o_pix[3]),
        .o_pix_4(o_pix[4]), .o_pix_5(o_pix[5]), .o_pix_6(o_pix[6]), .o_pix_7(o_pix[7]),
        .o_last_row(o_last_row)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // checks and watchdog
    always @(posedge i_clk) begin
        t_pix_row got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                for (int i = 0; i < 8; i++) got.pix[i] = o_pix[i];
                got.last_row = o_last_row;
                sb.check_row(got);
                rows_out++;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 5000) begin
                timed_out = 1;
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        int phase;
        if (!i_rst_n) begin
            i_stall <= 0;
            phase = 0;
        end else begin
            phase = (phase + 1) % 300;
            if (phase < 60)
                i_stall <= 0;
            else if (phase < 80)
                i_stall <= 1;
            else
                i_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    task automatic send_row(input logic signed [15:0] c [8]);
        i_valid <= 1;
        for (int i = 0; i < 8; i++) i_coef[i] <= c[i];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_row(c);
        rows_in++;
    endtask

    task automatic gap_maybe(inout int burst);
        if (burst > 0) begin
            burst--;
            return;
        end
        i_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
        burst = $urandom_range(0, 20);
    endtask

    function automatic logic signed [15:0] rand_coef(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 255) - 128);
            2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 4095) - 2048);
        endcase
    endfunction

    initial begin
        logic signed [15:0] c [8];
        int burst;
        int mode;
        sb = new();
        i_rst_n = 0;
        i_valid = 0;
        timed_out = 0;
        idle_cycles = 0;
        rows_in = 0;
        rows_out = 0;
        for (int i = 0; i < 8; i++) i_coef[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: lone maximum dc coefficient, alternating full-scale rows, single-bit patterns
        for (int r = 0; r < 24; r++) begin
            for (int i = 0; i < 8; i++) begin
                case (r / 8)
                    0: c[i] = (r == 0 && i == 0) ? 16'sh7fff : 16'sh0000;
                    1: c[i] = (r % 2) ? 16'sh8000 : 16'sh7fff;
                    default: c[i] = 16'sh0001 << ((r + i) % 16);
                endcase
            end
            send_row(c);
        end
        i_valid <= 0;

        burst = 0;
        for (int r = 0; r < 400; r++) begin
            if (r % 8 == 0) mode = $urandom_range(0, 5);
            for (int i = 0; i < 8; i++) c[i] = rand_coef(mode);
            if (mode == 4 && i_valid) c[0] = ~c[0];
            gap_maybe(burst);
            send_row(c);
        end
        i_valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("rows in %0d, pixel rows checked %0d, blocks %0d",
                 rows_in, rows_out, rows_out / 8);
        $display("covered saturating coefficients, sparse and dense blocks, random stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hdl
hdl/lic_pkg.sv
hdl/lic_idct1d.sv
hdl/lic_lane.sv
hdl/loeffler_idct_8x8_pixels_core.sv
hdl/lic_checker.sv
tb/tb.sv
